[rtl/twtt_pkg.sv]
// ----------------------------------------------------------------------------
// twtt_pkg
// Shared types and constants of the hashed timing wheel timer table.
// ----------------------------------------------------------------------------
`default_nettype none

package twtt_pkg;

	localparam int TIMEOUT_W = 20;
	localparam int ID_W      = 6;
	localparam int LINK_W    = 7;
	localparam int ROUND_W   = 14;
	localparam int OSLOT_W   = 6;
	localparam int DIV_DW    = TIMEOUT_W - 1;

	localparam logic [LINK_W-1:0]  NIL       = 7'd127;
	localparam logic [ROUND_W-1:0] ROUND_MAX = 14'd16383;

	typedef enum logic [1:0] {
		ACT_ADD  = 2'd0,
		ACT_DEL  = 2'd1,
		ACT_TICK = 2'd2,
		ACT_NONE = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		K_ADDED    = 3'd0,
		K_NEG      = 3'd1,
		K_FULL     = 3'd2,
		K_DELETED  = 3'd3,
		K_NOT_LIVE = 3'd4,
		K_EXPIRED  = 3'd5,
		K_NONE     = 3'd6,
		K_UNUSED   = 3'd7
	} kind_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIV1,
		ST_DIV2,
		ST_DIV3,
		ST_ADD_WR,
		ST_ADD_LINK,
		ST_UNL_RD,
		ST_UNL_WR,
		ST_WALK_HEAD,
		ST_WALK,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic [1:0]                  action;
		logic signed [TIMEOUT_W-1:0] timeout;
		logic [ID_W-1:0]             timer_id;
	} req_t;

	typedef struct packed {
		kind_t              kind;
		logic [ID_W-1:0]    timer_ref;
		logic [OSLOT_W-1:0] slot;
		logic [ROUND_W-1:0] rounds;
		logic               last;
	} rsp_t;

endpackage

`default_nettype wire

[rtl/timing_wheel_timer_table_top.sv]
// Negative, pool-full and not-live requests go straight to the result; a delete
//   unlinks in a read and a write step; an add runs the reciprocal divisions for
//   the ticks and the rotation, the slot remainder, the slot sum, then the link
//   writes. A tick reads the slot head, walks its entries, unlinks each expiry.
// One request in work at a time; the next is taken the cycle after the last result
//   enters the output register. Reset clears slot-head valid bits, live map, slot.
// ----------------------------------------------------------------------------
// timing_wheel_timer_table_top
// Hashed timing wheel timer table built around link and slot-head memories.
// ----------------------------------------------------------------------------
`default_nettype none

module timing_wheel_timer_table_top #(
	parameter int SLOTS         = 60,
	parameter int SLOT_INTERVAL = 1,
	parameter int MAX_TIMERS    = 64
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output logic                req_stall,
	input  wire twtt_pkg::req_t req,
	output logic                rsp_valid,
	input  wire logic           rsp_stall,
	output twtt_pkg::rsp_t      rsp
);

	import twtt_pkg::*;

	localparam int EW = $clog2(MAX_TIMERS);
	localparam int SW = $clog2(SLOTS);
	localparam int RW = ROUND_W + SW;

	state_t state_q, state_d;

	logic [1:0]         act_q;
	logic [EW-1:0]      e_q, e_next;
	logic [LINK_W-1:0]  nx_q, pv_q, h_q;
	logic [SW-1:0]      s_q, cur_q;
	logic [ROUND_W-1:0] rot_q;
	logic [EW:0]        guard_q;
	logic [MAX_TIMERS-1:0] live_q;
	logic [SLOTS-1:0]   hv_q;
	logic               hv_rd_q;
	rsp_t               pend_q;
	logic               pend_vld_q;
	rsp_t               rsp_q;
	logic               rsp_vld_q;
	logic [DIV_DW-1:0]  ticks_q;
	logic [DIV_DW-1:0]  quot_q;
	logic [SW-1:0]      rem_q;

	// memory ports
	logic              nx_we, pv_we, rs_we, hd_we;
	logic [EW-1:0]     nx_wa, pv_wa;
	logic [LINK_W-1:0] nx_wd, pv_wd, hd_wd;
	logic [RW-1:0]     rs_wd;
	logic [SW-1:0]     hd_ra;
	logic [LINK_W-1:0] nx_rd, pv_rd, hd_rd;
	logic [RW-1:0]     rs_rd;

	// constant dividers
	logic [DIV_DW-1:0] tq_raw, rq_raw;

	logic               req_ok, can_emit, full, id_live, unl_ok, rsp_load;
	logic [LINK_W-1:0]  hd, hn;
	logic [ROUND_W-1:0] rc;
	logic [SW-1:0]      es;
	logic [DIV_DW-1:0]  ticks_new, mulv, diffv;
	logic [SW:0]        ssum;
	logic [SW-1:0]      s_new;
	logic [ROUND_W-1:0] rot_new;
	logic [EW-1:0]      free_idx;
	logic               walk_head_ok, walk_nx_ok, walk_unl_ok;
	rsp_t               rej_rsp, fin_rsp;

	function automatic logic walk_ok(input logic [LINK_W-1:0] x,
	                                 input logic [MAX_TIMERS-1:0] lv,
	                                 input logic [EW:0] g);
		logic r;
		r = 1'b0;
		if (int'(x) < MAX_TIMERS) begin
			r = lv[x[EW-1:0]] && (int'(g) < MAX_TIMERS);
		end
		return r;
	endfunction

	// decode and helpers
	always_comb begin
		req_ok   = req_valid && !req_stall;
		can_emit = !rsp_vld_q || !rsp_stall;
		full     = &live_q;
		id_live  = (int'(req.timer_id) < MAX_TIMERS) && live_q[EW'(req.timer_id)];
		hd       = hv_rd_q ? hd_rd : NIL;
		rc       = rs_rd[RW-1:SW];
		es       = rs_rd[SW-1:0];
		hn       = (hd == LINK_W'(e_q)) ? nx_q : hd;
		unl_ok   = !pend_vld_q || can_emit;
		rsp_load = ((state_q == ST_FIN) && can_emit) ||
		           ((state_q == ST_UNL_WR) && unl_ok && pend_vld_q);
		ticks_new = (tq_raw == '0) ? DIV_DW'(1) : tq_raw;
		mulv     = quot_q * DIV_DW'(SLOTS);
		diffv    = ticks_q - mulv;
		ssum     = {1'b0, cur_q} + {1'b0, rem_q};
		s_new    = (int'(ssum) >= SLOTS) ? SW'(int'(ssum) - SLOTS) : ssum[SW-1:0];
		rot_new  = (rq_raw > DIV_DW'(ROUND_MAX)) ? ROUND_MAX : rq_raw[ROUND_W-1:0];
		free_idx = '0;
		for (int i = MAX_TIMERS - 1; i >= 0; i--) begin
			if (!live_q[i]) begin
				free_idx = EW'(i);
			end
		end
		walk_head_ok = walk_ok(hd, live_q, guard_q);
		walk_nx_ok   = walk_ok(nx_rd, live_q, guard_q + 1'b1);
		walk_unl_ok  = walk_ok(nx_q, live_q & ~(MAX_TIMERS'(1) << e_q), guard_q);
		rej_rsp = '{kind: K_FULL, timer_ref: '0, slot: '0, rounds: '0, last: 1'b0};
		if (req.action == ACT_DEL) rej_rsp.kind = K_NOT_LIVE;
		else if (req.timeout[TIMEOUT_W-1]) rej_rsp.kind = K_NEG;
		fin_rsp = pend_vld_q ? pend_q :
		          '{kind: K_NONE, timer_ref: '0, slot: OSLOT_W'(cur_q),
		            rounds: '0, last: 1'b0};
		fin_rsp.last = 1'b1;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_ok) begin
					case (req.action)
						ACT_ADD:  state_d = (req.timeout[TIMEOUT_W-1] || full) ? ST_FIN : ST_DIV1;
						ACT_DEL:  state_d = id_live ? ST_UNL_RD : ST_FIN;
						ACT_TICK: state_d = ST_WALK_HEAD;
						default:  state_d = ST_IDLE;
					endcase
				end
			end
			ST_DIV1:      state_d = ST_DIV2;
			ST_DIV2:      state_d = ST_DIV3;
			ST_DIV3:      state_d = ST_ADD_WR;
			ST_ADD_WR:    state_d = ST_ADD_LINK;
			ST_ADD_LINK:  state_d = ST_FIN;
			ST_UNL_RD:    state_d = ST_UNL_WR;
			ST_UNL_WR: begin
				if (unl_ok) begin
					if (act_q == ACT_DEL) state_d = ST_FIN;
					else state_d = walk_unl_ok ? ST_WALK : ST_FIN;
				end
			end
			ST_WALK_HEAD: state_d = walk_head_ok ? ST_WALK : ST_FIN;
			ST_WALK: begin
				if (rc != '0) state_d = walk_nx_ok ? ST_WALK : ST_FIN;
				else state_d = ST_UNL_RD;
			end
			ST_FIN:       if (can_emit) state_d = ST_IDLE;
			default:      state_d = ST_IDLE;
		endcase
	end

	// memory controls
	always_comb begin
		nx_we = 1'b0; nx_wa = e_q; nx_wd = hd;
		pv_we = 1'b0; pv_wa = e_q; pv_wd = NIL;
		rs_we = 1'b0; rs_wd = {rot_q, s_q};
		hd_we = 1'b0; hd_wd = LINK_W'(e_q);
		hd_ra = s_q;
		e_next = e_q;
		case (state_q)
			ST_IDLE: begin
				hd_ra = cur_q;
				if (req_ok) begin
					e_next = EW'(req.timer_id);
				end
			end
			ST_DIV3: begin
				hd_ra  = s_new;
				e_next = free_idx;
			end
			ST_ADD_WR: begin
				nx_we = 1'b1;
				pv_we = 1'b1;
				rs_we = 1'b1;
				hd_we = 1'b1;
			end
			ST_ADD_LINK: begin
				pv_we = int'(h_q) < MAX_TIMERS;
				pv_wa = h_q[EW-1:0];
				pv_wd = LINK_W'(e_q);
			end
			ST_UNL_RD: hd_ra = es;
			ST_UNL_WR: begin
				if (unl_ok) begin
					hd_we = hd == LINK_W'(e_q);
					hd_wd = nx_q;
					nx_we = (hd != LINK_W'(e_q)) && (int'(pv_q) < MAX_TIMERS);
					nx_wa = pv_q[EW-1:0];
					nx_wd = nx_q;
					pv_we = int'(nx_q) < MAX_TIMERS;
					pv_wa = nx_q[EW-1:0];
					pv_wd = (hn == nx_q) ? NIL : pv_q;
					if (act_q == ACT_TICK && walk_unl_ok) e_next = nx_q[EW-1:0];
				end
			end
			ST_WALK_HEAD: if (walk_head_ok) e_next = hd[EW-1:0];
			ST_WALK: begin
				if (rc != '0) begin
					rs_we = 1'b1;
					rs_wd = {rc - 1'b1, es};
					if (walk_nx_ok) e_next = nx_rd[EW-1:0];
				end
			end
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			live_q     <= '0;
			hv_q       <= '0;
			hv_rd_q    <= 1'b0;
			cur_q      <= '0;
			pend_vld_q <= 1'b0;
			rsp_vld_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			hv_rd_q <= hv_q[hd_ra];
			if (hd_we) hv_q[s_q] <= 1'b1;
			if (rsp_load) rsp_vld_q <= 1'b1;
			else if (!rsp_stall) rsp_vld_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (req_ok) begin
						case (req.action)
							ACT_ADD: pend_vld_q <= req.timeout[TIMEOUT_W-1] || full;
							ACT_DEL: pend_vld_q <= !id_live;
							default: pend_vld_q <= 1'b0;
						endcase
					end
				end
				ST_ADD_WR:   live_q[e_q] <= 1'b1;
				ST_ADD_LINK: pend_vld_q <= 1'b1;
				ST_UNL_WR: begin
					if (unl_ok) begin
						live_q[e_q] <= 1'b0;
						pend_vld_q  <= 1'b1;
					end
				end
				ST_FIN: begin
					if (can_emit) begin
						pend_vld_q <= 1'b0;
						if (act_q == ACT_TICK) begin
							cur_q <= (int'(cur_q) == SLOTS - 1) ? '0 : cur_q + 1'b1;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		e_q <= e_next;
		case (state_q)
			ST_IDLE: begin
				if (req_ok) begin
					act_q   <= req.action;
					guard_q <= '0;
					pend_q  <= rej_rsp;
					ticks_q <= ticks_new;
				end
			end
			ST_DIV1: begin
				quot_q <= rq_raw;
				rot_q  <= rot_new;
			end
			ST_DIV2: rem_q <= diffv[SW-1:0];
			ST_DIV3: s_q <= s_new;
			ST_ADD_WR: h_q <= hd;
			ST_ADD_LINK: begin
				pend_q <= '{kind: K_ADDED, timer_ref: ID_W'(e_q), slot: OSLOT_W'(s_q),
				            rounds: rot_q, last: 1'b0};
			end
			ST_UNL_RD: begin
				nx_q <= nx_rd;
				pv_q <= pv_rd;
				s_q  <= es;
			end
			ST_UNL_WR: begin
				if (unl_ok) begin
					if (pend_vld_q) rsp_q <= pend_q;
					pend_q <= '{kind: (act_q == ACT_DEL) ? K_DELETED : K_EXPIRED,
					            timer_ref: ID_W'(e_q), slot: OSLOT_W'(s_q),
					            rounds: '0, last: 1'b0};
				end
			end
			ST_WALK: guard_q <= guard_q + 1'b1;
			ST_FIN: begin
				if (can_emit) begin
					rsp_q <= fin_rsp;
				end
			end
			default: ;
		endcase
	end

	twtt_div #(.DW(DIV_DW), .DIVISOR(SLOT_INTERVAL)) u_div_ival (
		.dividend(req.timeout[DIV_DW-1:0]), .quot(tq_raw)
	);

	twtt_div #(.DW(DIV_DW), .DIVISOR(SLOTS)) u_div_slots (
		.dividend(ticks_q), .quot(rq_raw)
	);

	twtt_ram #(.WIDTH(LINK_W), .DEPTH(MAX_TIMERS)) u_next (
		.clk(clk), .we(nx_we), .waddr(nx_wa), .wdata(nx_wd), .raddr(e_next), .rdata(nx_rd)
	);

	twtt_ram #(.WIDTH(LINK_W), .DEPTH(MAX_TIMERS)) u_prev (
		.clk(clk), .we(pv_we), .waddr(pv_wa), .wdata(pv_wd), .raddr(e_next), .rdata(pv_rd)
	);

	twtt_ram #(.WIDTH(RW), .DEPTH(MAX_TIMERS)) u_round (
		.clk(clk), .we(rs_we), .waddr(e_q), .wdata(rs_wd), .raddr(e_next), .rdata(rs_rd)
	);

	twtt_ram #(.WIDTH(LINK_W), .DEPTH(SLOTS)) u_head (
		.clk(clk), .we(hd_we), .waddr(s_q), .wdata(hd_wd), .raddr(hd_ra), .rdata(hd_rd)
	);

	assign req_stall = state_q != ST_IDLE;
	assign rsp_valid = rsp_vld_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

[rtl/twtt_ram.sv]
// ----------------------------------------------------------------------------
// twtt_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module twtt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write, then read old contents
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

[rtl/twtt_div.sv]
// ----------------------------------------------------------------------------
// twtt_div
// Division by a constant through reciprocal multiplication, exact for any
// dividend below 2**DW.
// ----------------------------------------------------------------------------
`default_nettype none

module twtt_div #(
	parameter int DW      = 19,
	parameter int DIVISOR = 60
) (
	input  wire logic [DW-1:0] dividend,
	output logic      [DW-1:0] quot
);

	localparam int SH = DW + $clog2(DIVISOR);
	localparam int PW = SH + DW + 1;
	localparam longint unsigned RECIP =
		((64'd1 << SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);

	logic [PW-1:0] prod;

	// multiply by the rounded-up reciprocal; only DW by DW+1 bits carry data
	always_comb begin
		prod = PW'(dividend) * PW'(RECIP);
		quot = prod[SH +: DW];
	end

endmodule

`default_nettype wire

[rtl/twtt_chk.sv]
// ----------------------------------------------------------------------------
// twtt_chk
// Port-level checks of the timer table, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module twtt_chk (
	input wire logic           clk,
	input wire logic           arst_n,
	input wire logic           req_valid,
	input wire logic           req_stall,
	input wire twtt_pkg::req_t req,
	input wire logic           rsp_valid,
	input wire logic           rsp_stall,
	input wire twtt_pkg::rsp_t rsp
);

	import twtt_pkg::*;

	// hold a stalled result
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled result changed");

	// one request in work at a time
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && req.action != ACT_NONE |=> req_stall)
		else $error("request taken while busy");

	// single-result kinds always close their request
	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.kind != K_EXPIRED |-> rsp.last)
		else $error("single result without last");

	// rounds only on an add
	a_rounds: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.kind != K_ADDED |-> rsp.rounds == '0)
		else $error("rounds on non-add result");

endmodule

bind timing_wheel_timer_table_top twtt_chk u_twtt_chk (
	.clk(clk), .arst_n(arst_n), .req_valid(req_valid), .req_stall(req_stall),
	.req(req), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
);

`default_nettype wire

[sim/tb_timing_wheel_timer_table_top.sv]
// ----------------------------------------------------------------------------
// tb_timing_wheel_timer_table_top
// Drives adds, deletes and ticks into the timing wheel with random gaps and
// result back-pressure, predicts every result from a behavioural wheel of its
// own and compares each returned result field by field in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_timing_wheel_timer_table_top;
	timeunit 1ns;
	timeprecision 1ps;

	import twtt_pkg::*;

	localparam int NSLOT = 60;
	localparam int NENT  = 64;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	// wheel model state
	logic [6:0]  head_m [NSLOT];
	logic [6:0]  next_m [NENT];
	logic [6:0]  prev_m [NENT];
	logic [13:0] rot_m  [NENT];
	logic [5:0]  eslot_m [NENT];
	logic [63:0] live_m;
	int          cur_m;

	rsp_t pending_rsp [$];
	int   mismatches = 0;
	int   stall_left = 0;

	timing_wheel_timer_table_top dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	initial begin
		#50ms;
		$display("end of test: mismatches");
		$finish;
	end

	function automatic rsp_t mk(kind_t k, int r, int s, int rn);
		rsp_t o;
		o.kind = k; o.timer_ref = r[5:0]; o.slot = s[5:0];
		o.rounds = rn[13:0]; o.last = 1'b0;
		return o;
	endfunction

	function automatic void unlink_timer(int e);
		int s, nx, pv;
		s = eslot_m[e]; nx = next_m[e]; pv = prev_m[e];
		if (head_m[s] == e) begin
			head_m[s] = nx[6:0];
		end else if (pv < NENT) begin
			next_m[pv] = nx[6:0];
		end
		if (nx < NENT)
			prev_m[nx] = (head_m[s] == nx) ? NIL : pv[6:0];
		live_m[e] = 1'b0;
	endfunction

	// advance the wheel model by one request and queue its results
	function automatic void predict_wheel(req_t r);
		rsp_t o [$];
		int ticks, rt, s, e, cs, nx, guard;
		case (action_t'(r.action))
			ACT_ADD: begin
				if (r.timeout < 0) begin
					o.push_back(mk(K_NEG, 0, 0, 0));
				end else begin
					ticks = (r.timeout < 1) ? 1 : int'(r.timeout);
					rt = ticks / NSLOT;
					if (rt > ROUND_MAX) rt = ROUND_MAX;
					s = (cur_m + ticks % NSLOT) % NSLOT;
					e = NENT;
					for (int i = NENT - 1; i >= 0; i--)
						if (!live_m[i]) e = i;
					if (e == NENT) begin
						o.push_back(mk(K_FULL, 0, 0, 0));
					end else begin
						next_m[e] = head_m[s];
						prev_m[e] = NIL;
						if (head_m[s] < NENT) prev_m[head_m[s]] = e[6:0];
						head_m[s] = e[6:0];
						rot_m[e] = rt[13:0];
						eslot_m[e] = s[5:0];
						live_m[e] = 1'b1;
						o.push_back(mk(K_ADDED, e, s, rt));
					end
				end
			end
			ACT_DEL: begin
				if (live_m[r.timer_id]) begin
					s = eslot_m[r.timer_id];
					unlink_timer(r.timer_id);
					o.push_back(mk(K_DELETED, r.timer_id, s, 0));
				end else begin
					o.push_back(mk(K_NOT_LIVE, 0, 0, 0));
				end
			end
			ACT_TICK: begin
				cs = cur_m; e = head_m[cs]; guard = 0;
				while (e < NENT && live_m[e] && guard < NENT) begin
					nx = next_m[e];
					guard++;
					if (rot_m[e] > 0) begin
						rot_m[e]--;
					end else begin
						unlink_timer(e);
						o.push_back(mk(K_EXPIRED, e, cs, 0));
					end
					e = nx;
				end
				if (o.size() == 0) o.push_back(mk(K_NONE, 0, cs, 0));
				cur_m = (cs + 1) % NSLOT;
			end
			default: ;
		endcase
		if (o.size() > 0) o[o.size()-1].last = 1'b1;
		foreach (o[i]) pending_rsp.push_back(o[i]);
	endfunction

	// hand one request over, predicting it once accepted
	task automatic send_request(logic [1:0] act, int tmo, int id);
		int gap;
		gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= '{action: act, timeout: tmo[19:0], timer_id: id[5:0]};
		@(posedge clk);
		while (req_stall) @(posedge clk);
		predict_wheel('{action: act, timeout: tmo[19:0], timer_id: id[5:0]});
	endtask

	// hold the result side off for a drawn number of cycles per result
	always @(posedge clk) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
			stall_left = 0;
		end else if (rsp_valid && !rsp_stall) begin
			stall_left = $urandom_range(0, 17);
			rsp_stall <= (stall_left != 0);
		end else if (rsp_valid && stall_left > 0) begin
			stall_left--;
			rsp_stall <= (stall_left != 0);
		end
	end

	// compare each accepted result with the oldest expectation
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_rsp.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %p", rsp);
			end else begin
				want = pending_rsp.pop_front();
				if (rsp.kind !== want.kind || rsp.timer_ref !== want.timer_ref ||
				    rsp.slot !== want.slot || rsp.rounds !== want.rounds ||
				    rsp.last !== want.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %p actual %p", want, rsp);
				end
			end
		end
	end

	task automatic arm_timer(int tmo);
		send_request(ACT_ADD, tmo, $urandom_range(0, 63));
	endtask

	task automatic tick_wheel();
		send_request(ACT_TICK, $urandom, $urandom_range(0, 63));
	endtask

	task automatic test_directed();
		arm_timer(0);
		arm_timer(1);
		arm_timer(59);
		arm_timer(60);
		arm_timer(524287);
		arm_timer(-1);
		arm_timer(-524288);
		send_request(ACT_DEL, 0, 1);
		send_request(ACT_DEL, 0, 1);
		send_request(ACT_DEL, 0, 63);
		send_request(ACT_NONE, 12345, 42);
		tick_wheel();
		tick_wheel();
		tick_wheel();
		send_request(ACT_DEL, 0, 2);
	endtask

	// fill the pool, hit the full case, then drain part of it
	task automatic test_pool_full();
		for (int i = 0; i < 66; i++) arm_timer($urandom_range(0, 3));
		for (int i = 0; i < 3; i++) tick_wheel();
		for (int i = 0; i < 64; i += 6) send_request(ACT_DEL, 0, i);
	endtask

	task automatic test_random();
		int pick;
		for (int i = 0; i < 25; i++) begin
			pick = $urandom_range(0, 19);
			if (pick < 7)
				arm_timer($urandom_range(0, 7) == 0 ? $urandom : $urandom_range(0, 150));
			else if (pick < 11)
				send_request(ACT_DEL, $urandom, $urandom_range(0, 63));
			else if (pick < 19)
				tick_wheel();
			else
				send_request(ACT_NONE, $urandom, $urandom_range(0, 63));
		end
	endtask

	initial begin
		int waited;
		for (int i = 0; i < NSLOT; i++) head_m[i] = NIL;
		live_m = '0;
		cur_m = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_pool_full();
		test_random();
		req_valid <= 1'b0;
		waited = 0;
		while (pending_rsp.size() != 0 && waited < 100000) begin
			@(posedge clk);
			waited++;
		end
		repeat (300) @(posedge clk);
		if (mismatches == 0 && pending_rsp.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

`default_nettype wire

[files.f]
rtl/twtt_pkg.sv
rtl/twtt_ram.sv
rtl/twtt_div.sv
rtl/timing_wheel_timer_table_top.sv
rtl/twtt_chk.sv
sim/tb_timing_wheel_timer_table_top.sv
